FILE: src/k_way_merge_of_sorted_runs_top_defines.svh
// assertion macros for the k-way merge block
`ifndef K_WAY_MERGE_OF_SORTED_RUNS_TOP_DEFINES_SVH
`define K_WAY_MERGE_OF_SORTED_RUNS_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KWM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kwm: same-cycle check failed");

// next-cycle implication, checked out of reset
`define KWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kwm: next-cycle check failed");

`endif

FILE: src/kwm_pkg.sv
// types, constants and helpers shared by the k-way merge block
package kwm_pkg;

    localparam int NUM_RUNS    = 16;
    localparam int RUN_W       = $clog2(NUM_RUNS);
    localparam int RUN_CNT_W   = 5;
    localparam int KEY_W       = 32;
    localparam int PAYLOAD_W   = 32;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_END    = 1'b1;

    localparam logic [RUN_CNT_W-1:0] RUN_COUNT_RST = RUN_CNT_W'(NUM_RUNS);

    typedef logic [NUM_RUNS-1:0] t_run_mask;

    // input beat
    typedef struct packed {
        logic                    cmd;
        logic [RUN_W-1:0]        run;
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    payload;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [PAYLOAD_W-1:0]    out_payload;
        logic [RUN_W-1:0]        out_run;
        logic                    done_res;
    } t_out_beat;

    // one head record held by a cell
    typedef struct packed {
        logic                    valid;
        logic [RUN_W-1:0]        run;
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    payload;
    } t_head;

    // per-cell control from the top level
    typedef struct packed {
        logic en;
        logic ins;
        logic left_b;
        logic shift;
    } t_cell_ctl;

    // merge order: signed key, lower run first on equal keys
    function automatic logic head_less(t_head a, t_head b);
        logic lt;
        if (a.key != b.key) begin
            lt = ($signed(a.key) < $signed(b.key));
        end else begin
            lt = (a.run < b.run);
        end
        return lt;
    endfunction

endpackage

FILE: src/kwm_cell.sv
// one slot of the sorted head list: insert compare and shift toward the head
module kwm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kwm_pkg::t_head     i_new,
    input  kwm_pkg::t_head     i_left,
    input  kwm_pkg::t_head     i_right_merged,
    input  kwm_pkg::t_cell_ctl i_ctl,
    output logic               o_b,
    output kwm_pkg::t_head     o_head,
    output kwm_pkg::t_head     o_merged
);

    kwm_pkg::t_head r_head;
    kwm_pkg::t_head n_head;
    logic           goes_ahead;

    // new record goes ahead of this slot when the slot is empty or larger
    assign goes_ahead = !r_head.valid || kwm_pkg::head_less(i_new, r_head);
    assign o_b        = i_ctl.ins && goes_ahead;

    // list after the insert: take the left neighbor, the new record or keep
    always_comb begin
        if (o_b) begin
            o_merged = i_ctl.left_b ? i_left : i_new;
        end else begin
            o_merged = r_head;
        end
        n_head = i_ctl.shift ? i_right_merged : o_merged;
    end

    // slot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_ctl.en) begin
            r_head <= n_head;
        end
    end

    assign o_head = r_head;

endmodule

FILE: src/k_way_merge_of_sorted_runs_top.sv
// k-way merge of key-sorted runs: top level with run flags and output register
//
// Input channel (i_in_valid / i_in_beat / o_in_stall): each beat either brings
// the next record of a run (cmd record) or marks that run as ended. Output
// channel (o_out_valid / o_out_beat / i_out_stall): the smallest held key with
// its payload and run index, or one final done beat once every run has ended.
// i_cfg_we / i_cfg_data set the number of runs; write it only while idle.
// Heads sit in a chain of sixteen cells kept in merge order; a beat is
// inserted by a compare in every cell at once and the smallest active head
// leaves by shifting the chain, both in the same cycle.
// A result caused by a beat is on the output in the cycle after the beat is
// taken. The block takes one beat per cycle while the output is not stalled,
// as the cell chain inserts and shifts in the same cycle.
// Reset clears every head, every run-ended flag, the done flag and the output
// register, and sets the run count to sixteen.
// While the receiver stalls a waiting result, the input is stalled too; the
// held result stays unchanged until taken.
`include "k_way_merge_of_sorted_runs_top_defines.svh"

module k_way_merge_of_sorted_runs_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  kwm_pkg::t_in_beat                   i_in_beat,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output kwm_pkg::t_out_beat                  o_out_beat,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [kwm_pkg::RUN_CNT_W-1:0]       i_cfg_data
);

    localparam logic [kwm_pkg::NUM_RUNS:0] NUM_RUNS_ONE = (kwm_pkg::NUM_RUNS + 1)'(1);

    logic [kwm_pkg::RUN_CNT_W-1:0] r_run_count;
    logic [kwm_pkg::RUN_CNT_W-1:0] eff_n;
    kwm_pkg::t_run_mask            r_head_valid;
    kwm_pkg::t_run_mask            n_head_valid;
    kwm_pkg::t_run_mask            r_run_ended;
    kwm_pkg::t_run_mask            n_run_ended;
    kwm_pkg::t_run_mask            hv_upd;
    kwm_pkg::t_run_mask            run_active;
    kwm_pkg::t_run_mask            act;
    kwm_pkg::t_run_mask            seen;
    kwm_pkg::t_run_mask            first;
    kwm_pkg::t_run_mask            cell_valid;
    kwm_pkg::t_run_mask            cell_b;
    kwm_pkg::t_run_mask            run_bit;
    logic                          r_done_sent;
    logic                          r_out_valid;
    kwm_pkg::t_out_beat            r_out;
    kwm_pkg::t_out_beat            n_out;
    kwm_pkg::t_head                new_head;
    kwm_pkg::t_head                best;
    kwm_pkg::t_head                cell_head   [kwm_pkg::NUM_RUNS];
    kwm_pkg::t_head                cell_merged [kwm_pkg::NUM_RUNS];
    kwm_pkg::t_cell_ctl            cell_ctl    [kwm_pkg::NUM_RUNS];
    logic                          accept;
    logic                          in_act;
    logic                          ins;
    logic                          ready;
    logic                          found;
    logic                          pop;
    logic                          emit_done;

    // input is taken when the output slot is free or drains this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // effective run count, clamped to one through the cell count
    always_comb begin
        if (r_run_count == '0) begin
            eff_n = kwm_pkg::RUN_CNT_W'(1);
        end else if (r_run_count > kwm_pkg::RUN_COUNT_RST) begin
            eff_n = kwm_pkg::RUN_COUNT_RST;
        end else begin
            eff_n = r_run_count;
        end
    end

    // run count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= kwm_pkg::RUN_COUNT_RST;
        end else if (i_cfg_we) begin
            r_run_count <= i_cfg_data;
        end
    end

    // which runs take part
    always_comb begin
        for (int i = 0; i < kwm_pkg::NUM_RUNS; i++) begin
            run_active[i] = (kwm_pkg::RUN_CNT_W'(i) < eff_n);
        end
    end

    // decode of the incoming beat
    assign in_act  = ({1'b0, i_in_beat.run} < eff_n);
    assign run_bit = kwm_pkg::t_run_mask'(1) << i_in_beat.run;
    assign ins     = accept && (i_in_beat.cmd == kwm_pkg::CMD_RECORD) && in_act
                     && !r_run_ended[i_in_beat.run] && !r_head_valid[i_in_beat.run];

    always_comb begin
        new_head         = '0;
        new_head.valid   = 1'b1;
        new_head.run     = i_in_beat.run;
        new_head.key     = i_in_beat.key;
        new_head.payload = i_in_beat.payload;
    end

    // flags after this beat is taken in
    always_comb begin
        n_run_ended = r_run_ended;
        if (accept && (i_in_beat.cmd == kwm_pkg::CMD_END) && in_act) begin
            n_run_ended = r_run_ended | run_bit;
        end
        hv_upd = ins ? (r_head_valid | run_bit) : r_head_valid;
    end

    assign ready = &(hv_upd | n_run_ended | ~run_active);

    // cell chain
    for (genvar g = 0; g < kwm_pkg::NUM_RUNS; g++) begin : g_cell
        localparam kwm_pkg::t_run_mask LOW_MASK =
            kwm_pkg::t_run_mask'((NUM_RUNS_ONE << (g + 1)) - 1);
        kwm_pkg::t_head left_head;
        kwm_pkg::t_head right_merged;

        if (g == 0) begin : g_first
            assign left_head         = '0;
            assign cell_ctl[g].left_b = 1'b0;
        end else begin : g_mid
            assign left_head         = cell_head[g-1];
            assign cell_ctl[g].left_b = cell_b[g-1];
        end

        // the list never holds more than one head per run, so past the last
        // cell nothing is ever valid
        if (g == kwm_pkg::NUM_RUNS - 1) begin : g_last
            assign right_merged = '0;
        end else begin : g_inner
            assign right_merged = cell_merged[g+1];
        end

        assign cell_ctl[g].en    = accept;
        assign cell_ctl[g].ins   = ins;
        assign cell_ctl[g].shift = pop && seen[g];

        kwm_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_new          (new_head),
            .i_left         (left_head),
            .i_right_merged (right_merged),
            .i_ctl          (cell_ctl[g]),
            .o_b            (cell_b[g]),
            .o_head         (cell_head[g]),
            .o_merged       (cell_merged[g])
        );

        // active heads and the first one in merge order
        assign cell_valid[g] = cell_head[g].valid;
        assign act[g]        = cell_merged[g].valid && run_active[cell_merged[g].run];
        assign seen[g]       = |(act & LOW_MASK);
        if (g == 0) begin : g_first_sel
            assign first[g] = act[g];
        end else begin : g_next_sel
            assign first[g] = act[g] && !seen[g-1];
        end
    end

    // smallest active head after the insert
    always_comb begin
        best = '0;
        for (int i = 0; i < kwm_pkg::NUM_RUNS; i++) begin
            best = best | (first[i] ? cell_merged[i] : '0);
        end
    end

    assign found     = |act;
    assign pop       = accept && ready && found;
    assign emit_done = accept && ready && !found && !r_done_sent;

    // run flags after the pop
    always_comb begin
        n_head_valid = hv_upd;
        if (pop) begin
            n_head_valid = hv_upd & ~(kwm_pkg::t_run_mask'(1) << best.run);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_run_ended  <= '0;
            r_done_sent  <= 1'b0;
        end else if (accept) begin
            r_head_valid <= n_head_valid;
            r_run_ended  <= n_run_ended;
            r_done_sent  <= r_done_sent || emit_done;
        end
    end

    // output beat
    always_comb begin
        n_out = '0;
        if (pop) begin
            n_out.out_key     = best.key;
            n_out.out_payload = best.payload;
            n_out.out_run     = best.run;
        end else begin
            n_out.done_res    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop || emit_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (pop || emit_done) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // checks
    `KWM_ASSERT_NOW(a_list_matches_flags, 1'b1, $countones(cell_valid) == $countones(r_head_valid))
    `KWM_ASSERT_NOW(a_list_packed, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0)
    `KWM_ASSERT_NOW(a_done_when_empty, emit_done, !(|act))
    `KWM_ASSERT_NEXT(a_done_once, r_done_sent, !emit_done)

endmodule

FILE: tb/tb_k_way_merge_of_sorted_runs_top.sv
// self-checking testbench for the k-way merge of sorted runs
`timescale 1ns / 100ps

module tb_k_way_merge_of_sorted_runs_top;

    localparam int IDLE_LIMIT  = 400;
    localparam int PHASE_BEATS = 165;
    localparam int MAX_REPORTS = 40;

    // merge predictor and queue of result beats still owed by the block
    class merge_scoreboard;
        logic [kwm_pkg::RUN_CNT_W-1:0]    runs_cfg = kwm_pkg::RUN_COUNT_RST;
        logic signed [kwm_pkg::KEY_W-1:0] held_key [kwm_pkg::NUM_RUNS];
        logic [kwm_pkg::PAYLOAD_W-1:0]    held_payload [kwm_pkg::NUM_RUNS];
        bit                               has_head [kwm_pkg::NUM_RUNS];
        bit                               is_ended [kwm_pkg::NUM_RUNS];
        bit                               done_given;
        kwm_pkg::t_out_beat               owed_q [$];
        int                               n_errors;
        int                               n_checked;
        int                               n_records;

        // out-of-range counts clamp to one and to the full set
        function int active_runs();
            if (runs_cfg == 0) begin
                return 1;
            end
            if (runs_cfg > kwm_pkg::NUM_RUNS) begin
                return kwm_pkg::NUM_RUNS;
            end
            return int'(runs_cfg);
        endfunction

        function void set_run_count(logic [kwm_pkg::RUN_CNT_W-1:0] v);
            runs_cfg = v;
        endfunction

        // take one accepted input beat and queue the result it causes
        function void note_input(kwm_pkg::t_in_beat b);
            int                 n;
            int                 best;
            bit                 ready;
            bit                 found;
            kwm_pkg::t_out_beat res;
            n = active_runs();
            if (b.run < n) begin
                if (b.cmd == kwm_pkg::CMD_END) begin
                    is_ended[b.run] = 1'b1;
                end else if (!is_ended[b.run] && !has_head[b.run]) begin
                    held_key[b.run]     = b.key;
                    held_payload[b.run] = b.payload;
                    has_head[b.run]     = 1'b1;
                end
            end
            ready = 1'b1;
            for (int r = 0; r < n; r++) begin
                if (!has_head[r] && !is_ended[r]) begin
                    ready = 1'b0;
                end
            end
            if (!ready) begin
                return;
            end
            // smallest signed key, strict compare keeps the lower run on ties
            found = 1'b0;
            best  = 0;
            for (int r = 0; r < n; r++) begin
                if (has_head[r] && (!found || held_key[r] < held_key[best])) begin
                    best  = r;
                    found = 1'b1;
                end
            end
            res = '0;
            if (found) begin
                has_head[best]  = 1'b0;
                res.out_key     = held_key[best];
                res.out_payload = held_payload[best];
                res.out_run     = kwm_pkg::RUN_W'(best);
                owed_q.insert(owed_q.size(), res);
                n_records++;
            end else if (!done_given) begin
                done_given   = 1'b1;
                res.done_res = 1'b1;
                owed_q.insert(owed_q.size(), res);
            end
        endfunction

        function void flag(string what, logic [kwm_pkg::KEY_W-1:0] want,
                           logic [kwm_pkg::KEY_W-1:0] got);
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            end
        endfunction

        // compare one accepted result beat with the oldest owed one
        function void check_result(kwm_pkg::t_out_beat got);
            kwm_pkg::t_out_beat want;
            if (owed_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("%0t: result beat with none expected, expected nothing actual %p",
                             $time, got);
                end
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            if (got.out_key !== want.out_key) begin
                flag("out_key", want.out_key, got.out_key);
            end
            if (got.out_payload !== want.out_payload) begin
                flag("out_payload", want.out_payload, got.out_payload);
            end
            if (got.out_run !== want.out_run) begin
                flag("out_run", kwm_pkg::KEY_W'(want.out_run), kwm_pkg::KEY_W'(got.out_run));
            end
            if (got.done_res !== want.done_res) begin
                flag("done_res", kwm_pkg::KEY_W'(want.done_res),
                     kwm_pkg::KEY_W'(got.done_res));
            end
        endfunction
    endclass

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_in_valid = 1'b0;
    kwm_pkg::t_in_beat             i_in_beat  = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    kwm_pkg::t_out_beat            o_out_beat;
    logic                          i_out_stall = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [kwm_pkg::RUN_CNT_W-1:0] i_cfg_data  = '0;

    merge_scoreboard                  sb;
    bit                               steady;
    int                               ends_left = 6;
    int                               n_beats;
    int                               n_settings;
    int                               idle_cycles;
    int                               stall_left;
    logic signed [kwm_pkg::KEY_W-1:0] run_last_key [kwm_pkg::NUM_RUNS];

    k_way_merge_of_sorted_runs_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // wait drawn per beat on either side, none in steady stretches
    function automatic int draw_wait();
        if (steady) begin
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // next key of a run: ascending with small steps so ties across runs are common
    function automatic logic signed [kwm_pkg::KEY_W-1:0] next_key(input int r);
        longint k;
        k = longint'(run_last_key[r]) + longint'($urandom_range(0, 3));
        if ($urandom_range(0, 31) == 0) begin
            k = k + longint'($urandom_range(0, 65535));
        end
        if (k > 64'sh7fffffff) begin
            k = 64'sh7fffffff;
        end
        run_last_key[r] = k[kwm_pkg::KEY_W-1:0];
        return k[kwm_pkg::KEY_W-1:0];
    endfunction

    // common starting key for all runs of a phase
    function automatic void start_keys();
        logic signed [kwm_pkg::KEY_W-1:0] base;
        case ($urandom_range(0, 3))
            0: begin
                base = 32'sh80000000;
            end
            1: begin
                base = 32'sh7fffff00;
            end
            default: begin
                base = $urandom;
            end
        endcase
        foreach (run_last_key[r]) begin
            run_last_key[r] = base;
        end
    endfunction

    // well-formed feeder beat: refill a run that lacks a head, or nudge the merge
    function automatic kwm_pkg::t_in_beat merge_beat(input bit finishing);
        kwm_pkg::t_in_beat b;
        int                n;
        int                alive;
        int                pick;
        int                hungry [$];
        int                stale [$];
        n     = sb.active_runs();
        alive = 0;
        b     = '0;
        b.payload = $urandom;
        for (int r = 0; r < n; r++) begin
            if (sb.is_ended[r]) begin
                stale.insert(stale.size(), r);
            end else begin
                alive++;
                if (!sb.has_head[r]) begin
                    hungry.insert(hungry.size(), r);
                end
            end
        end
        if (hungry.size() > 0) begin
            pick  = hungry[$urandom_range(0, hungry.size() - 1)];
            b.run = kwm_pkg::RUN_W'(pick);
            if (finishing || (ends_left > 0 && alive > 3 && $urandom_range(0, 149) == 0)) begin
                b.cmd = kwm_pkg::CMD_END;
                if (!finishing) begin
                    ends_left--;
                end
            end else begin
                b.cmd = kwm_pkg::CMD_RECORD;
                b.key = next_key(pick);
            end
        end else if (stale.size() > 0) begin
            // nothing to refill: a repeated end lets the next head out
            b.cmd = kwm_pkg::CMD_END;
            b.run = kwm_pkg::RUN_W'(stale[$urandom_range(0, stale.size() - 1)]);
        end else begin
            b.cmd = kwm_pkg::CMD_RECORD;
            b.run = kwm_pkg::RUN_W'($urandom_range(0, n - 1));
            b.key = $urandom;
        end
        return b;
    endfunction

    // noise: records to random, full or ended runs, ends to inactive or ended runs
    function automatic kwm_pkg::t_in_beat noise_beat();
        kwm_pkg::t_in_beat b;
        int                n;
        int                stale [$];
        int                busy [$];
        n         = sb.active_runs();
        b.cmd     = kwm_pkg::CMD_RECORD;
        b.run     = kwm_pkg::RUN_W'($urandom_range(0, kwm_pkg::NUM_RUNS - 1));
        b.key     = $urandom;
        b.payload = $urandom;
        for (int r = 0; r < kwm_pkg::NUM_RUNS; r++) begin
            if (sb.is_ended[r]) begin
                stale.insert(stale.size(), r);
            end
            if (sb.is_ended[r] || sb.has_head[r]) begin
                busy.insert(busy.size(), r);
            end
        end
        case ($urandom_range(0, 2))
            1: begin
                if (n < kwm_pkg::NUM_RUNS) begin
                    b.cmd = kwm_pkg::CMD_END;
                    b.run = kwm_pkg::RUN_W'($urandom_range(kwm_pkg::NUM_RUNS - 1, n));
                end else if (stale.size() > 0) begin
                    b.cmd = kwm_pkg::CMD_END;
                    b.run = kwm_pkg::RUN_W'(stale[$urandom_range(0, stale.size() - 1)]);
                end
            end
            2: begin
                if (busy.size() > 0) begin
                    b.run = kwm_pkg::RUN_W'(busy[$urandom_range(0, busy.size() - 1)]);
                end
            end
            default: begin
            end
        endcase
        return b;
    endfunction

    // drive one input beat after a drawn gap and hold it until taken
    task automatic send_beat(input kwm_pkg::t_in_beat b);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_input(b);
        n_beats++;
    endtask

    task automatic send_fields(input logic cmd, input int run,
                               input logic signed [kwm_pkg::KEY_W-1:0] key,
                               input logic [kwm_pkg::PAYLOAD_W-1:0] payload);
        kwm_pkg::t_in_beat b;
        b.cmd     = cmd;
        b.run     = kwm_pkg::RUN_W'(run);
        b.key     = key;
        b.payload = payload;
        send_beat(b);
    endtask

    // stop sending until every owed result is out, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_run_count(input logic [kwm_pkg::RUN_CNT_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_run_count(v);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // result side: check taken beats, stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_beat);
            stall_left = draw_wait();
        end else if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = draw_wait();
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no beat taken on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat taken for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned phase_runs [10] = '{16, 5, 2, 31, 9, 17, 3, 16, 12, 16};
        int          merged;
        sb = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of sixteen lets run 15 take a head
        send_fields(kwm_pkg::CMD_RECORD, 15, 32'sh7fffffff, 32'hffffffff);

        // a count of zero acts as a single run
        write_run_count(kwm_pkg::RUN_CNT_W'(0));
        send_fields(kwm_pkg::CMD_RECORD, 0, 32'sh80000000, 32'h00000000);
        send_fields(kwm_pkg::CMD_RECORD, 0, 32'sh7fffffff, 32'hffffffff);
        send_fields(kwm_pkg::CMD_RECORD, 5, 32'sh00000123, 32'h00000001);
        send_fields(kwm_pkg::CMD_END, 15, 32'sh00000000, 32'h00000000);
        send_fields(kwm_pkg::CMD_RECORD, 0, -32'sd1, 32'h12345678);
        write_run_count(kwm_pkg::RUN_CNT_W'(1));
        send_fields(kwm_pkg::CMD_RECORD, 0, 32'sh00000000, 32'h5a5a5a5a);

        // two runs: held head kept, end while held, ended run ignores records, ties
        write_run_count(kwm_pkg::RUN_CNT_W'(2));
        send_fields(kwm_pkg::CMD_RECORD, 0, 32'sd10, 32'h0000000a);
        send_fields(kwm_pkg::CMD_RECORD, 0, -32'sd5, 32'h0000000b);
        send_fields(kwm_pkg::CMD_END, 0, 32'sd0, 32'h00000000);
        send_fields(kwm_pkg::CMD_RECORD, 0, 32'sd3, 32'h0000000c);
        send_fields(kwm_pkg::CMD_RECORD, 1, 32'sd10, 32'ha5a5a5a5);
        send_fields(kwm_pkg::CMD_END, 0, 32'sd0, 32'h00000000);
        send_fields(kwm_pkg::CMD_END, 0, 32'sd0, 32'h00000000);
        send_fields(kwm_pkg::CMD_RECORD, 1, -32'sd7, 32'hdeadbeef);
        send_fields(kwm_pkg::CMD_RECORD, 1, -32'sd7, 32'h0badf00d);

        // random phases over several run counts
        foreach (phase_runs[p]) begin
            write_run_count(kwm_pkg::RUN_CNT_W'(phase_runs[p]));
            start_keys();
            steady = ($urandom_range(0, 2) == 0);
            merged = 0;
            while (merged < PHASE_BEATS) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_beat(noise_beat());
                end else begin
                    send_beat(merge_beat(1'b0));
                    merged++;
                end
            end
        end

        // end every run, flush the heads and take the done beat
        write_run_count(kwm_pkg::RUN_CNT_W'(16));
        steady = 1'b0;
        while (!sb.done_given) begin
            send_beat(merge_beat(1'b1));
        end
        send_fields(kwm_pkg::CMD_END, 3, 32'sd0, 32'h00000000);
        send_fields(kwm_pkg::CMD_RECORD, 2, 32'sd99, 32'h00000063);
        write_run_count(kwm_pkg::RUN_CNT_W'(3));
        send_fields(kwm_pkg::CMD_END, 1, 32'sd0, 32'h00000000);

        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d input beats over %0d run_count settings, %0d records merged",
                 n_beats, n_settings, sb.n_records);
        $display("%0d result beats checked, %0d errors", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.owed_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: k_way_merge_of_sorted_runs_top.f
+incdir+src
src/kwm_pkg.sv
src/kwm_cell.sv
src/k_way_merge_of_sorted_runs_top.sv
tb/tb_k_way_merge_of_sorted_runs_top.sv
